/* hw/rtl/fdfc_pkg.sv */
// shared widths, register codes and handshake structs for the fractional delay comb
package fdfc_pkg;

  // payload field widths
  localparam int CH_W     = 1;
  localparam int SAMPLE_W = 16;
  localparam int WIDX_W   = 14;
  localparam int DLY_W    = 22;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 8;

  // stream word widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;

  // configuration port
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;
  localparam int CFG_LEN_W  = 15;
  localparam int CFG_LEN_MAX = 2 ** CFG_LEN_W - 1;

  typedef enum logic [0:0] {
    REG_RING_LENGTH = 1'b0
  } cfg_reg_t;

  // remainder unit request and status
  typedef struct packed {
    logic             start;
    logic [DLY_W-1:0] numer;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_rsp_t;

endpackage

/* hw/rtl/fdfc_mod_unit.sv */
// bit-serial restoring remainder unit, one numerator bit per cycle
module fdfc_mod_unit #(
  parameter int DEN_W = 23
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fdfc_pkg::mod_req_t  req,
  input  logic [DEN_W-1:0]    den,
  output fdfc_pkg::mod_rsp_t  rsp,
  output logic [DEN_W-1:0]    rem
);

  localparam int NUM_W = fdfc_pkg::DLY_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // shift in the next bit, subtract when it fits
  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = diff[DEN_W-1:0];
    end else begin
      rem_nxt = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.numer;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rem      = rem_r;

endmodule

/* hw/rtl/fdfc_ring_mem.sv */
// delay ring storage for all channels with a clearing sweep after reset
module fdfc_ring_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fdfc_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [fdfc_pkg::SAMPLE_W-1:0] rdata,
  output logic                          clearing
);

  logic [fdfc_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [fdfc_pkg::SAMPLE_W-1:0] rdata_r;
  logic [AW-1:0]                 clr_cnt_r;
  logic                          clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata    = rdata_r;
  assign clearing = clearing_r;

endmodule

/* hw/rtl/fractional_delay_feedback_comb_core.sv */
// top level of the fractional delay feedback comb: sequencer, datapath and register port
//
// Each accepted word carries one sample for one channel; the block reads that channel's
// ring at write_index - delay_amount (8 fraction bits, wrapped by the ring length in use),
// interpolates linearly between two neighboring entries, multiplies by feedback_gain,
// rounds, adds the input, saturates to Q1.15, writes the result back at write_index and
// returns it. A new word is not taken until the sequencer has finished with the last one;
// the wrapping is done by one shared bit-serial remainder unit that runs twice per word
// (write position and delay, 22 steps each), followed by a position state, two ring reads
// on the single read port, a tap multiply, an interpolation add, the gain multiply and a
// final round, saturate and write state. in_tready is high only while the sequencer is
// idle; a finished result sits in the output register, so the next word is taken while it
// waits, and that word stalls in its final state until the register is free. After reset
// the ring is zeroed by a sweep over all CHANNELS * RING_DEPTH entries (32768 by default)
// before the first word is accepted; register writes are taken during the sweep. ring_length
// below 2 acts as 2 and above the ring depth acts as the depth; write_index is wrapped by
// the length in use.
module fractional_delay_feedback_comb_core #(
  parameter int RING_DEPTH = 16384,
  parameter int CHANNELS   = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_in[15:0], write_index[29:16], delay_amount[51:30], feedback_gain[67:52], zeros
  input  logic [fdfc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // channel[0]
  input  logic [fdfc_pkg::CH_W-1:0]         in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // sample_out[15:0]
  output logic [fdfc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // register port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fdfc_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [fdfc_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [fdfc_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int SW        = fdfc_pkg::SAMPLE_W;
  localparam int FW        = fdfc_pkg::FRAC_W;
  localparam int LEN_MAX   = (RING_DEPTH < fdfc_pkg::CFG_LEN_MAX) ? RING_DEPTH
                                                                   : fdfc_pkg::CFG_LEN_MAX;
  localparam int LEN_W     = $clog2(LEN_MAX + 1);
  localparam int SPAN_W    = LEN_W + FW;
  localparam int IDX_W     = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int MT_W      = SW + FW + 1;   // interpolation term and sum
  localparam int PROD_W    = MT_W + fdfc_pkg::GAIN_W;
  localparam int SCL_W     = PROD_W - (SW + FW - 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MODW = 10'b00_0000_0010,
    S_MODD = 10'b00_0000_0100,
    S_POS  = 10'b00_0000_1000,
    S_RDA  = 10'b00_0001_0000,
    S_RDB  = 10'b00_0010_0000,
    S_MUL1 = 10'b00_0100_0000,
    S_INTP = 10'b00_1000_0000,
    S_MUL2 = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------- register port
  logic [fdfc_pkg::CFG_LEN_W-1:0] ring_length_r;
  logic                           cfg_wr;
  logic                           cfg_sel_len;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_len = (cfg_paddr[fdfc_pkg::CFG_AW-1] == fdfc_pkg::REG_RING_LENGTH);
  assign cfg_wr      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_length_r <= fdfc_pkg::CFG_LEN_W'(16384);
    end else if (cfg_wr && cfg_sel_len) begin
      ring_length_r <= cfg_pwdata[fdfc_pkg::CFG_LEN_W-1:0];
    end
  end

  always_comb begin
    if (cfg_sel_len) begin
      cfg_prdata = {{(fdfc_pkg::CFG_DW - fdfc_pkg::CFG_LEN_W){1'b0}}, ring_length_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  // clamp the length in use, span is the length in 1/256 sample units
  logic [LEN_W-1:0]  len_used;
  logic [SPAN_W-1:0] span;

  always_comb begin
    if (ring_length_r < fdfc_pkg::CFG_LEN_W'(2)) begin
      len_used = LEN_W'(2);
    end else if ({2'b00, ring_length_r} > 17'(LEN_MAX)) begin
      len_used = LEN_W'(LEN_MAX);
    end else begin
      len_used = LEN_W'(ring_length_r);
    end
  end

  assign span = {len_used, {FW{1'b0}}};

  // ---------------------------------------------------------------- input fields
  logic                 in_acc;
  logic                 ch_r;
  logic [SW-1:0]        x_r;
  logic [fdfc_pkg::DLY_W-1:0]  dly_r;
  logic [fdfc_pkg::GAIN_W-1:0] fb_r;

  assign in_acc = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= (CHANNELS > 1) ? in_tuser[0] : 1'b0;
      x_r   <= in_tdata[15:0];
      dly_r <= in_tdata[51:30];
      fb_r  <= in_tdata[67:52];
    end
  end

  // ---------------------------------------------------------------- remainder unit
  fdfc_pkg::mod_req_t mod_req;
  fdfc_pkg::mod_rsp_t mod_rsp;
  logic [SPAN_W-1:0]  mod_rem;

  fdfc_mod_unit #(
    .DEN_W (SPAN_W)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .den   (span),
    .rsp   (mod_rsp),
    .rem   (mod_rem)
  );

  // first pass wraps write_index * 256, second pass wraps the delay
  always_comb begin
    mod_req.start = 1'b0;
    mod_req.numer = dly_r;
    if (state_r == S_IDLE) begin
      mod_req.start = in_acc;
      mod_req.numer = {in_tdata[29:16], {FW{1'b0}}};
    end else if (state_r == S_MODW) begin
      mod_req.start = mod_rsp.done;
    end
  end

  // ---------------------------------------------------------------- ring storage
  logic              ring_we;
  logic [MEM_AW-1:0] ring_raddr;
  logic [SW-1:0]     ring_rdata;
  logic              clearing;
  logic [SW-1:0]     sat_val;

  logic [MEM_AW-1:0] a_addr_r, b_addr_r, w_addr_r;

  assign ring_raddr = (state_r == S_RDB) ? b_addr_r : a_addr_r;

  fdfc_ring_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (ring_we),
    .waddr    (w_addr_r),
    .wdata    (sat_val),
    .raddr    (ring_raddr),
    .rdata    (ring_rdata),
    .clearing (clearing)
  );

  // ---------------------------------------------------------------- read position
  logic [SPAN_W-1:0] rw_r;     // wrapped write position, 1/256 units
  logic [SPAN_W-1:0] pos_r;
  logic [SPAN_W-1:0] pos_nxt;
  logic [FW-1:0]     frac_r;
  logic [LEN_W:0]    i1_ext;
  logic [IDX_W-1:0]  i0_idx, i1_idx, w_idx;
  logic [MEM_AW-1:0] ch_base;

  always_comb begin
    if (rw_r >= mod_rem) begin
      pos_nxt = rw_r - mod_rem;
    end else begin
      pos_nxt = rw_r + (span - mod_rem);
    end
  end

  // second tap wraps to entry zero at the length in use
  always_comb begin
    i1_ext = {1'b0, pos_r[SPAN_W-1:FW]} + (LEN_W + 1)'(1);
    i0_idx = IDX_W'(pos_r[SPAN_W-1:FW]);
    if (i1_ext >= {1'b0, len_used}) begin
      i1_idx = '0;
    end else begin
      i1_idx = IDX_W'(i1_ext);
    end
    w_idx   = IDX_W'(rw_r[SPAN_W-1:FW]);
    ch_base = ch_r ? MEM_AW'(RING_DEPTH) : '0;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MODW && mod_rsp.done) begin
      rw_r <= mod_rem;
    end
    if (state_r == S_MODD && mod_rsp.done) begin
      pos_r <= pos_nxt;
    end
    if (state_r == S_POS) begin
      frac_r   <= pos_r[FW-1:0];
      a_addr_r <= ch_base + MEM_AW'(i0_idx);
      b_addr_r <= ch_base + MEM_AW'(i1_idx);
      w_addr_r <= ch_base + MEM_AW'(w_idx);
    end
  end

  // ---------------------------------------------------------------- arithmetic
  logic [SW-1:0]            a_r;
  logic signed [SW:0]       tap_diff;
  logic signed [MT_W:0]     frac_prod;
  logic signed [MT_W-1:0]   mterm_r;
  logic signed [MT_W-1:0]   interp_r;
  logic signed [MT_W-1:0]   interp_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] biased;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [SCL_W:0]    sum;

  always_comb begin
    tap_diff   = $signed({ring_rdata[SW-1], ring_rdata}) - $signed({a_r[SW-1], a_r});
    frac_prod  = $signed({1'b0, frac_r}) * tap_diff;
    interp_nxt = $signed({a_r[SW-1], a_r, {FW{1'b0}}}) + mterm_r;
    prod_nxt   = interp_r * $signed(fb_r);
    // scale by 2^-23, round to nearest with ties up
    biased     = prod_r + $signed(PROD_W'(1) << (SW + FW - 2));
    scaled     = biased[PROD_W-1:SW+FW-1];
    sum        = $signed({scaled[SCL_W-1], scaled})
               + $signed({{(SCL_W + 1 - SW){x_r[SW-1]}}, x_r});
    if (sum > $signed((SCL_W + 1)'(32767))) begin
      sat_val = 16'h7FFF;
    end else if (sum < -$signed((SCL_W + 1)'(32768))) begin
      sat_val = 16'h8000;
    end else begin
      sat_val = sum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RDB) begin
      a_r <= ring_rdata;
    end
    if (state_r == S_MUL1) begin
      mterm_r <= frac_prod[MT_W-1:0];
    end
    if (state_r == S_INTP) begin
      interp_r <= interp_nxt;
    end
    if (state_r == S_MUL2) begin
      prod_r <= prod_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  logic          out_valid_r;
  logic [SW-1:0] out_data_r;
  logic          fin_go;

  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign ring_we = fin_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= sat_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- sequencer
  assign in_tready = (state_r == S_IDLE) && !clearing;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_MODW;
      end
      S_MODW: begin
        if (mod_rsp.done) state_nxt = S_MODD;
      end
      S_MODD: begin
        if (mod_rsp.done) state_nxt = S_POS;
      end
      S_POS:  state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_INTP;
      S_INTP: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_FIN;
      S_FIN: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- checks
  a_mod_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mod_req.start |-> !mod_rsp.busy)
    else $error("remainder unit restarted while busy");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_MODW || state_r == S_MODD))
    else $error("remainder result arrived outside a wait state");

  a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POS) |-> (pos_r < span))
    else $error("read position outside the ring span");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> !clearing)
    else $error("ring write during clearing sweep");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MODW && mod_rsp.busy))
    else $error("accepted word did not start the remainder unit");

endmodule

/* test/tb_top.sv */
// self-checking testbench for the fractional delay feedback comb core
`timescale 1ns / 1ps

module tb_top;

  localparam int RING_DEPTH     = 16384;
  localparam int CHANNELS       = 2;
  localparam int WORD_TARGET    = 1850;
  localparam int RANDOM_PHASES  = 8;
  localparam int STALL_LIMIT    = 150000;  // covers the ring clearing sweep several times
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 100;
  localparam logic [fdfc_pkg::CFG_AW-1:0] RING_LENGTH_ADDR =
    fdfc_pkg::CFG_AW'(4 * int'(fdfc_pkg::REG_RING_LENGTH));

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t   kind;
    logic        ch;
    logic [15:0] sample;
    logic [13:0] widx;
    logic [21:0] dly;
    logic [15:0] gain;
    logic        typed;       // expected value written into the table
    logic [15:0] typed_out;
    logic [31:0] reg_value;
  } stim_row_t;

  typedef struct {
    int unsigned seq;
    logic [15:0] sample;
  } sample_expect_t;

  logic                                 clk;
  logic                                 rst_n       = 1'b0;
  logic                                 in_tvalid   = 1'b0;
  logic                                 in_tready;
  logic [fdfc_pkg::IN_TDATA_W-1:0]      in_tdata    = '0;
  logic [fdfc_pkg::CH_W-1:0]            in_tuser    = '0;
  logic                                 out_tvalid;
  logic                                 out_tready  = 1'b0;
  logic [fdfc_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic                                 cfg_psel    = 1'b0;
  logic                                 cfg_penable = 1'b0;
  logic                                 cfg_pwrite  = 1'b0;
  logic [fdfc_pkg::CFG_AW-1:0]          cfg_paddr   = '0;
  logic [fdfc_pkg::CFG_DW-1:0]          cfg_pwdata  = '0;
  logic [fdfc_pkg::CFG_DW-1:0]          cfg_prdata;
  logic                                 cfg_pready;

  // testbench copy of the block state
  bit signed [15:0] ring_model [CHANNELS][RING_DEPTH];
  logic [fdfc_pkg::CFG_LEN_W-1:0] ring_len_cfg = fdfc_pkg::CFG_LEN_W'(RING_DEPTH);

  sample_expect_t sample_out_q [$];
  stim_row_t      directed_rows [$];
  sample_expect_t head;

  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned saturated_seen = 0;
  int unsigned mismatches     = 0;
  int unsigned length_writes  = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  logic        rx_steady      = 1'b0;

  fractional_delay_feedback_comb_core #(
    .RING_DEPTH(RING_DEPTH),
    .CHANNELS  (CHANNELS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void log_mismatch(input string what, input int unsigned seq,
                                       input logic [31:0] expected, input logic [31:0] actual);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s word %0d: expected %h actual %h at %0t",
               what, seq, expected, actual, $realtime);
  endfunction

  // lengths outside 2..depth are clamped by the block
  function automatic int unsigned effective_length();
    int unsigned n;
    n = 32'(ring_len_cfg);
    if (n < 2) n = 2;
    if (n > RING_DEPTH) n = RING_DEPTH;
    return n;
  endfunction

  // interpolated tap times gain plus input, rounded and saturated; updates the ring copy
  function automatic logic [15:0] predict_comb_output(input logic ch,
                                                      input logic signed [15:0] x,
                                                      input logic [13:0] widx,
                                                      input logic [21:0] dly,
                                                      input logic signed [15:0] gain);
    int unsigned len, w, span, d, pos, i0, i1, frac;
    longint a, b, interp, prod, scaled, total;
    len  = effective_length();
    w    = widx % len;
    span = len << 8;
    d    = dly % span;
    pos  = ((w << 8) + span - d) % span;
    i0   = pos >> 8;
    frac = pos & 8'hFF;
    i1   = (i0 + 1 >= len) ? 0 : i0 + 1;
    a = longint'(ring_model[ch][i0]);
    b = longint'(ring_model[ch][i1]);
    interp = a * 256 + longint'(frac) * (b - a);
    prod   = interp * longint'(gain);
    // round half up, then drop the 23 scale bits
    scaled = (prod + (longint'(1) << 22)) >>> 23;
    total  = scaled + longint'(x);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    ring_model[ch][w] = total[15:0];
    return total[15:0];
  endfunction

  function automatic void add_word(input logic ch, input logic [15:0] sample,
                                   input logic [13:0] widx, input logic [21:0] dly,
                                   input logic [15:0] gain, input logic typed,
                                   input logic [15:0] typed_out);
    stim_row_t r;
    r = '{ROW_WORD, ch, sample, widx, dly, gain, typed, typed_out, 32'd0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_reg(input logic [31:0] value);
    stim_row_t r;
    r = '{ROW_REG, 1'b0, 16'd0, 14'd0, 22'd0, 16'd0, 1'b0, 16'd0, value};
    directed_rows.push_back(r);
  endfunction

  // offer one word, hold it until taken, then queue its expected result
  task automatic send_word(input logic ch, input logic [15:0] sample, input logic [13:0] widx,
                           input logic [21:0] dly, input logic [15:0] gain,
                           input logic typed, input logic [15:0] typed_out);
    sample_expect_t e;
    logic [15:0] predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= ch;
    in_tdata  <= {4'b0, gain, dly, widx, sample};
    do @(posedge clk); while (!in_tready);
    predicted = predict_comb_output(ch, sample, widx, dly, gain);
    e.seq     = words_sent;
    e.sample  = typed ? typed_out : predicted;
    sample_out_q.push_back(e);
    words_sent++;
  endtask

  task automatic wait_drained();
    while (sample_out_q.size() != 0) @(posedge clk);
  endtask

  // setup and access phases for the write, then the same for a read back
  task automatic write_ring_length(input logic [31:0] value);
    logic [31:0] readback;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= RING_LENGTH_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    ring_len_cfg = value[fdfc_pkg::CFG_LEN_W-1:0];
    length_writes++;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== {{(fdfc_pkg::CFG_DW-fdfc_pkg::CFG_LEN_W){1'b0}},
                      value[fdfc_pkg::CFG_LEN_W-1:0]})
      log_mismatch("ring_length readback", words_sent, value, readback);
  endtask

  // receiver: random backpressure, a no-stall mode, and long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 15);
    end
  end

  // result checker: every output word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tdata == 16'h7FFF || out_tdata == 16'h8000) saturated_seen++;
      if (sample_out_q.size() == 0) begin
        log_mismatch("unexpected sample_out", results_seen, 32'hFFFF_FFFF, 32'(out_tdata));
      end else begin
        head = sample_out_q.pop_front();
        if (out_tdata !== head.sample)
          log_mismatch("sample_out", head.seq, 32'(head.sample), 32'(out_tdata));
      end
    end
  end

  // watchdog: ends the run when no word moves on either stream for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // main sequence: directed table, then random phases over several ring lengths
  initial begin : stimulus
    int unsigned phase_len [RANDOM_PHASES];
    int unsigned per_phase, len, seq_widx;
    logic        ch;
    logic [15:0] sample, gain;
    logic [13:0] widx;
    logic [21:0] dly;

    // ring starts cleared and at full length, so the first rows can be read off directly
    add_reg(32'd16384);
    add_word(1'b0, 16'h7FFF, 14'd0,     22'd0,      16'h7FFF, 1'b1, 16'h7FFF); // empty ring
    add_word(1'b1, 16'h8000, 14'd0,     22'd0,      16'h8000, 1'b1, 16'h8000); // other ring empty
    add_word(1'b0, 16'h8000, 14'd1,     22'd256,    16'h7FFF, 1'b0, 16'h0000);
    add_word(1'b0, 16'h7FFF, 14'd2,     22'd512,    16'h7FFF, 1'b1, 16'h7FFF); // clip high
    add_word(1'b0, 16'h8000, 14'd3,     22'd768,    16'h8000, 1'b1, 16'h8000); // clip low
    add_word(1'b0, 16'd100,  14'd4,     22'd896,    16'd20000, 1'b0, 16'h0000); // half step
    add_word(1'b1, 16'd1,    14'd10,    22'd256,    16'h0000, 1'b1, 16'd1);    // zero gain
    add_word(1'b1, 16'd0,    14'd11,    22'd256,    16'h4000, 1'b1, 16'd1);    // tie rounds up
    add_word(1'b1, 16'd0,    14'd12,    22'd512,    16'hC000, 1'b1, 16'd0);    // negative tie
    add_word(1'b0, 16'd1234, 14'h3FFF,  22'h3FFFFF, 16'hCFC7, 1'b0, 16'h0000); // next tap wraps
    add_word(1'b1, 16'hFFFF, 14'd0,     22'd0,      16'hFFFF, 1'b0, 16'h0000);
    add_reg(32'd0);                                   // below minimum, acts as 2
    add_word(1'b0, 16'd300,  14'h3FFF,  22'h3FFFFF, 16'h7FFF, 1'b0, 16'h0000); // index wraps
    add_word(1'b0, 16'hFED4, 14'd2,     22'h155,    16'hB1E0, 1'b0, 16'h0000);
    add_reg(32'd1);
    add_word(1'b1, 16'd7,    14'd3,     22'd384,    16'd30000, 1'b0, 16'h0000);
    add_reg(32'd32767);                               // above depth, acts as depth
    add_word(1'b0, 16'd0,    14'd8191,  22'h3FFFFF, 16'h7FFF, 1'b0, 16'h0000);
    add_word(1'b0, 16'h5A5A, 14'd100,   22'h2A5A5,  16'h0000, 1'b1, 16'h5A5A); // zero gain
    add_reg(32'd2);
    add_word(1'b1, 16'hFFFF, 14'd1,     22'd128,    16'hFFFF, 1'b0, 16'h0000);
    add_reg(32'd5);
    add_word(1'b0, 16'd12,   14'd9,     22'd1000,   16'd25000, 1'b0, 16'h0000);
    add_reg(32'd16384);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        in_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_ring_length(directed_rows[i].reg_value);
      end else begin
        send_word(directed_rows[i].ch, directed_rows[i].sample, directed_rows[i].widx,
                  directed_rows[i].dly, directed_rows[i].gain, directed_rows[i].typed,
                  directed_rows[i].typed_out);
      end
    end

    // ring lengths for the random phases: extremes, clamped values and random sizes
    phase_len[0] = 16384;
    phase_len[1] = 2;
    phase_len[2] = 32767;
    phase_len[3] = $urandom_range(3, 64);
    phase_len[4] = 1;
    phase_len[5] = $urandom_range(65, 16383);
    phase_len[6] = 0;
    phase_len[7] = $urandom_range(6, 20);
    per_phase = (WORD_TARGET - words_sent) / RANDOM_PHASES;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_ring_length(phase_len[p]);
      len = effective_length();
      seq_widx = 0;
      // phase 1 runs with no idling on either side
      rx_steady <= (p == 1);
      // phase 3 starts with a long receiver hold-off while words keep coming
      if (p == 3) hold_requests <= hold_requests + 1;

      for (int n = 0; n < per_phase; n++) begin
        if (n < per_phase * 4 / 5) begin
          // well-formed: write position walks the ring, delay within one ring span or up to eight samples
          ch   = 1'($urandom_range(0, 1));
          widx = 14'(seq_widx);
          seq_widx = (seq_widx + 1) % len;
          if ($urandom_range(0, 3) == 0) dly = 22'($urandom_range(0, 8 * 256));
          else dly = 22'($urandom_range(0, len * 256 - 1));
        end else begin
          // noise: any value the fields allow
          ch   = 1'($urandom);
          widx = 14'($urandom);
          dly  = 22'($urandom);
        end
        sample = 16'($urandom);
        gain   = 16'($urandom);

        if (p == 5 && n == per_phase / 2) begin
          // sender stops until the block has emptied
          in_tvalid <= 1'b0;
          wait_drained();
        end else if (p != 1 && $urandom_range(0, 99) < 15) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 70)) @(posedge clk);
        end
        send_word(ch, sample, widx, dly, gain, 1'b0, 16'h0000);
      end
      rx_steady <= 1'b0;
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words and %0d results across %0d ring length writes",
             words_sent, results_seen, length_writes);
    $display("%0d results hit a clip limit, %0d mismatches", saturated_seen, mismatches);
    if (mismatches == 0 && sample_out_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
